FILE: rtl/core/stereo_biquad_cascade_eq_assert.svh
// Assertion macros shared by the equalizer modules.
// Depends on nothing; included by the lane and merge modules.
`ifndef STEREO_BIQUAD_CASCADE_EQ_ASSERT_SVH
`define STEREO_BIQUAD_CASCADE_EQ_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBQ_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBQ_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sbq_pkg.sv
// Shared types and constants for the stereo biquad cascade equalizer.
// Depends on nothing; used by every module of the block.
package sbq_pkg;

    localparam int NUM_BANDS_DEF      = 3;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 24;

    localparam int COEF_W     = 32;
    localparam int DELAY_W    = 48;
    localparam int NUM_COEFS  = 5;
    localparam int SEL_W      = 3;
    localparam int BAND_IDX_W = 3;
    localparam int CFG_W      = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 3'b001;

    localparam logic OP_PROCESS = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
    localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
    localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
    localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

    typedef struct packed {
        logic                     we;
        logic [BAND_IDX_W-1:0]    band;
        logic [SEL_W-1:0]         sel;
        logic signed [COEF_W-1:0] value;
    } coef_wr_t;

endpackage

FILE: rtl/core/sbq_lane.sv
// One channel lane: coefficient memory, band delays and a shared multiplier
// stepping through the biquad cascade. Depends on sbq_pkg and the assert header.
`include "stereo_biquad_cascade_eq_assert.svh"

module sbq_lane #(
    parameter int NUM_BANDS      = sbq_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic [NUM_BANDS-1:0]          band_en,
    input  sbq_pkg::coef_wr_t             wr,
    input  logic                          ack,
    output logic                          idle,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] y_out
);

    localparam int BAND_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int COEF_DEPTH  = NUM_BANDS * sbq_pkg::NUM_COEFS;
    localparam int AW          = $clog2(COEF_DEPTH);
    localparam int ADDR_FULL_W = sbq_pkg::BAND_IDX_W + sbq_pkg::SEL_W;
    localparam int COEF_W      = sbq_pkg::COEF_W;
    localparam int DELAY_W     = sbq_pkg::DELAY_W;
    localparam int PROD_W      = COEF_W + SAMPLE_BITS;
    localparam int ACC_W       = PROD_W + 2;

    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] D_MAX =
        {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] D_MIN =
        {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [COEF_W-1:0] COEF_ONE =
        {{(COEF_W-1){1'b0}}, 1'b1} << COEF_FRAC_BITS;

    typedef enum logic [3:0] {
        L_IDLE,
        L_FETCH,
        L_S0,
        L_S1,
        L_S2,
        L_S3,
        L_S4,
        L_S5,
        L_DONE
    } lane_state_t;

    function automatic logic [AW-1:0] coef_addr(
        input logic [sbq_pkg::BAND_IDX_W-1:0] band,
        input logic [sbq_pkg::SEL_W-1:0]      sel
    );
        logic [ADDR_FULL_W-1:0] full;
        full = ADDR_FULL_W'(band) * ADDR_FULL_W'(sbq_pkg::NUM_COEFS) + ADDR_FULL_W'(sel);
        return full[AW-1:0];
    endfunction

    lane_state_t                state_reg;
    logic [BAND_W-1:0]          band_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [DELAY_W-1:0]  z1_reg [NUM_BANDS];
    logic signed [DELAY_W-1:0]  z2_reg [NUM_BANDS];

    logic signed [COEF_W-1:0]   coef_mem [COEF_DEPTH];
    logic [COEF_DEPTH-1:0]      valid_reg;
    logic signed [COEF_W-1:0]   rd_data_reg;
    logic                       rd_valid_reg;
    logic                       rd_b0_reg;

    logic [sbq_pkg::SEL_W-1:0]  rd_sel;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    y_sum;
    logic signed [ACC_W-1:0]    y_shift;
    logic signed [SAMPLE_BITS-1:0] y_next;
    logic signed [ACC_W-1:0]    d_diff;
    logic signed [DELAY_W-1:0]  d_next;
    logic signed [ACC_W-1:0]    acc_s2;
    logic                       last_band;

    always_comb
    begin
        case (state_reg)
            L_FETCH: rd_sel = sbq_pkg::SEL_B0;
            L_S0:    rd_sel = sbq_pkg::SEL_B1;
            L_S1:    rd_sel = sbq_pkg::SEL_A1;
            L_S2:    rd_sel = sbq_pkg::SEL_B2;
            L_S3:    rd_sel = sbq_pkg::SEL_A2;
            default: rd_sel = sbq_pkg::SEL_B0;
        endcase
    end

    assign rd_addr   = coef_addr(sbq_pkg::BAND_IDX_W'(band_reg), rd_sel);
    assign wr_addr   = coef_addr(wr.band, wr.sel);
    assign coef      = rd_valid_reg ? rd_data_reg : (rd_b0_reg ? COEF_ONE : '0);
    assign mul_b     = (state_reg == L_S2 || state_reg == L_S4) ? y_reg : x_reg;
    assign prod_next = coef * mul_b;
    assign last_band = (band_reg == BAND_W'(NUM_BANDS - 1));

    assign y_sum   = ACC_W'(prod_reg) + ACC_W'(z1_reg[band_reg]) + HALF;
    assign y_shift = y_sum >>> COEF_FRAC_BITS;
    assign d_diff  = acc_reg - ACC_W'(prod_reg);
    assign acc_s2  = ACC_W'(prod_reg) + ACC_W'(z2_reg[band_reg]);

    always_comb
    begin
        if (y_shift > Y_MAX)
            y_next = Y_MAX[SAMPLE_BITS-1:0];
        else if (y_shift < Y_MIN)
            y_next = Y_MIN[SAMPLE_BITS-1:0];
        else
            y_next = y_shift[SAMPLE_BITS-1:0];

        if (d_diff > D_MAX)
            d_next = D_MAX[DELAY_W-1:0];
        else if (d_diff < D_MIN)
            d_next = D_MIN[DELAY_W-1:0];
        else
            d_next = d_diff[DELAY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
            coef_mem[wr_addr] <= wr.value;
        rd_data_reg <= coef_mem[rd_addr];
        rd_b0_reg   <= (rd_sel == sbq_pkg::SEL_B0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
                valid_reg[wr_addr] <= 1'b1;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            band_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else
        begin
            prod_reg <= prod_next;
            case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x_in;
                        band_reg  <= '0;
                        state_reg <= L_FETCH;
                    end
                end
                L_FETCH:
                begin
                    if (band_en[band_reg])
                        state_reg <= L_S0;
                    else if (last_band)
                        state_reg <= L_DONE;
                    else
                        band_reg <= band_reg + BAND_W'(1);
                end
                L_S0:
                begin
                    state_reg <= L_S1;
                end
                L_S1:
                begin
                    y_reg     <= y_next;
                    state_reg <= L_S2;
                end
                L_S2:
                begin
                    acc_reg   <= acc_s2;
                    state_reg <= L_S3;
                end
                L_S3:
                begin
                    z1_reg[band_reg] <= d_next;
                    state_reg        <= L_S4;
                end
                L_S4:
                begin
                    acc_reg   <= ACC_W'(prod_reg);
                    state_reg <= L_S5;
                end
                L_S5:
                begin
                    z2_reg[band_reg] <= d_next;
                    x_reg            <= y_reg;
                    if (last_band)
                        state_reg <= L_DONE;
                    else
                    begin
                        band_reg  <= band_reg + BAND_W'(1);
                        state_reg <= L_FETCH;
                    end
                end
                L_DONE:
                begin
                    if (ack)
                        state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign idle  = (state_reg == L_IDLE);
    assign done  = (state_reg == L_DONE);
    assign y_out = x_reg;

    `SBQ_ASSERT_IMPLY(a_start_idle, clk, rst_n, start, state_reg == L_IDLE,
        "sample request reached a busy lane")
    `SBQ_ASSERT_IMPLY(a_write_idle, clk, rst_n, wr.we, state_reg == L_IDLE,
        "coefficient write while lane busy")
    `SBQ_ASSERT_NEXT(a_band_end, clk, rst_n, state_reg == L_S5,
        state_reg == L_FETCH || state_reg == L_DONE, "band step did not advance")

endmodule

FILE: rtl/core/sbq_merge.sv
// Merge stage: joins the two lane results into one output pair and holds it
// for the downstream side. Depends on sbq_pkg and the assert header.
`include "stereo_biquad_cascade_eq_assert.svh"

module sbq_merge #(
    parameter int SAMPLE_BITS = sbq_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          l_done,
    input  logic                          r_done,
    input  logic signed [SAMPLE_BITS-1:0] l_y,
    input  logic signed [SAMPLE_BITS-1:0] r_y,
    output logic                          ack,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] right_reg;

    assign ack = l_done && r_done && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            right_reg     <= '0;
        end
        else
        begin
            if (ack)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= l_y;
                right_reg     <= r_y;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({right_reg, left_reg});

    `SBQ_ASSERT_IMPLY(a_ack_both, clk, rst_n, ack, l_done && r_done,
        "merge took a lane result early")
    `SBQ_ASSERT_IMPLY(a_lockstep, clk, rst_n, l_done || r_done, l_done && r_done,
        "lanes finished out of step")
    `SBQ_ASSERT_NEXT(a_ack_loads, clk, rst_n, ack, out_valid_reg,
        "merged pair not presented")

endmodule

FILE: rtl/core/stereo_biquad_cascade_eq.sv
// Stereo biquad cascade equalizer, top level. Depends on sbq_pkg, sbq_lane, sbq_merge.
// A sample request is taken only while both lanes are idle: a lane stays busy until
// the merge stage takes its result, which waits on m_tready while the output is full.
// Both lanes run the same sequencer; the per-lane multiplier steps each enabled band
// through L_FETCH and L_S0 to L_S5. Coefficient writes are also taken only while idle.
// Reset: pass-through coefficients, zero delays, band 0 enabled, output empty.
module stereo_biquad_cascade_eq #(
    parameter int NUM_BANDS      = sbq_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS    = sbq_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = sbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // left_in, right_in, coef_band, coef_channel, coef_select, coef_value
    input  logic [((2*SAMPLE_BITS+38+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    input  logic                                 cfg_we,
    input  logic [sbq_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int SB = SAMPLE_BITS;

    logic [sbq_pkg::CFG_W-1:0]       mask_reg;
    logic [NUM_BANDS-1:0]            band_en;
    logic                            accept;
    logic                            start;
    logic                            write_ok;
    logic [1:0]                      in_band;
    logic                            in_chan;
    logic [sbq_pkg::SEL_W-1:0]       in_sel;
    sbq_pkg::coef_wr_t               wr_l;
    sbq_pkg::coef_wr_t               wr_r;
    logic                            l_idle;
    logic                            r_idle;
    logic                            l_done;
    logic                            r_done;
    logic                            ack;
    logic signed [SB-1:0]            l_y;
    logic signed [SB-1:0]            r_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= sbq_pkg::CFG_RESET;
        else if (cfg_we)
            mask_reg <= cfg_wdata;
    end

    for (genvar b = 0; b < NUM_BANDS; b++)
    begin : g_en
        if (b < sbq_pkg::CFG_W)
        begin : g_on
            assign band_en[b] = mask_reg[b];
        end
        else
        begin : g_off
            assign band_en[b] = 1'b0;
        end
    end

    assign s_tready = l_idle && r_idle;
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && (s_tuser == sbq_pkg::OP_PROCESS);

    assign in_band  = s_tdata[2*SB+1:2*SB];
    assign in_chan  = s_tdata[2*SB+2];
    assign in_sel   = s_tdata[2*SB+5:2*SB+3];
    assign write_ok = accept && (s_tuser == sbq_pkg::OP_WRITE)
                      && (32'(in_band) < NUM_BANDS) && (in_sel <= sbq_pkg::SEL_A2);

    always_comb
    begin
        wr_l.we    = write_ok && !in_chan;
        wr_l.band  = sbq_pkg::BAND_IDX_W'(in_band);
        wr_l.sel   = in_sel;
        wr_l.value = s_tdata[2*SB+37:2*SB+6];
        wr_r       = wr_l;
        wr_r.we    = write_ok && in_chan;
    end

    sbq_lane #(
        .NUM_BANDS      (NUM_BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .x_in    (s_tdata[SB-1:0]),
        .band_en (band_en),
        .wr      (wr_l),
        .ack     (ack),
        .idle    (l_idle),
        .done    (l_done),
        .y_out   (l_y)
    );

    sbq_lane #(
        .NUM_BANDS      (NUM_BANDS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .x_in    (s_tdata[2*SB-1:SB]),
        .band_en (band_en),
        .wr      (wr_r),
        .ack     (ack),
        .idle    (r_idle),
        .done    (r_done),
        .y_out   (r_y)
    );

    sbq_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .l_done   (l_done),
        .r_done   (r_done),
        .l_y      (l_y),
        .r_y      (r_y),
        .ack      (ack),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
